@@ src/mpmf_pkg.sv @@
// shared types and register map for the mirror padded median filter
// no dependencies
`timescale 1ns / 1ps

package mpmf_pkg;

	localparam int CFG_W = 11;
	localparam int HALF_CFG_W = 2;
	localparam int PIX_W = 8;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_HALF_ROWS    = 2'd2,
		REG_HALF_COLS    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_FIN   = 4'b1000
	} back_state_t;

endpackage

@@ src/mpmf_front.sv @@
// front end: accepts pixel and drain transactions, tracks input and output raster
// positions, writes the line ring and queues window jobs; uses mpmf_pkg
`timescale 1ns / 1ps

module mpmf_front #(
	parameter int CW = 10,
	parameter int RW = 10,
	parameter int HW = 2,
	parameter int RB = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_restart,
	input  logic                     pix_valid,
	output logic                     pix_ready,
	input  logic                     action,
	input  logic [mpmf_pkg::PIX_W-1:0] pixel_in,
	input  logic [CW-1:0]            w_last,
	input  logic [RW-1:0]            h_last,
	input  logic [HW-1:0]            a_eff,
	input  logic [HW-1:0]            b_eff,
	input  logic                     back_idle,
	output logic                     mem_we,
	output logic [RB-1:0]            mem_wring,
	output logic [CW-1:0]            mem_wcol,
	output logic [mpmf_pkg::PIX_W-1:0] mem_wdata,
	output logic                     job_valid,
	output logic [RW-1:0]            job_row,
	output logic [CW-1:0]            job_col,
	output logic                     job_last,
	input  logic                     job_pop
);

	logic [RW-1:0] in_row_q, out_row_q, row_n, rmax, job_row_q;
	logic [CW-1:0] in_col_q, out_col_q, col_n, cmax, job_col_q;
	logic          frame_in_q, frame_n, job_valid_q, job_last_q;
	logic          acc, do_wr, rdy, push, last;
	logic [RW:0]   rsum;
	logic [CW:0]   csum;

	assign pix_ready = !job_valid_q && back_idle;
	assign acc = pix_valid && pix_ready;
	assign do_wr = acc && !action && !frame_in_q;

	assign mem_we = do_wr;
	assign mem_wring = RB'(in_row_q);
	assign mem_wcol = in_col_q;
	assign mem_wdata = pixel_in;

	always_comb begin
		row_n = in_row_q;
		col_n = in_col_q;
		frame_n = frame_in_q;
		if (do_wr) begin
			if (in_col_q != w_last) begin
				col_n = in_col_q + CW'(1);
			end else if (in_row_q != h_last) begin
				col_n = '0;
				row_n = in_row_q + RW'(1);
			end else begin
				frame_n = 1'b1;
			end
		end
	end

	// last pixel the next centre needs, compared against the write position
	assign rsum = {1'b0, out_row_q} + (RW+1)'(a_eff);
	assign csum = {1'b0, out_col_q} + (CW+1)'(b_eff);
	assign rmax = (rsum > {1'b0, h_last}) ? h_last : rsum[RW-1:0];
	assign cmax = (csum > {1'b0, w_last}) ? w_last : csum[CW-1:0];
	assign rdy = frame_n || (rmax < row_n) || ((rmax == row_n) && (cmax < col_n));
	assign push = acc && rdy;
	assign last = (out_col_q == w_last) && (out_row_q == h_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			frame_in_q <= 1'b0;
		end else if (cfg_restart || (push && last)) begin
			in_row_q <= '0;
			in_col_q <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			frame_in_q <= 1'b0;
		end else if (acc) begin
			in_row_q <= row_n;
			in_col_q <= col_n;
			frame_in_q <= frame_n;
			if (push) begin
				if (out_col_q != w_last) begin
					out_col_q <= out_col_q + CW'(1);
				end else begin
					out_col_q <= '0;
					out_row_q <= out_row_q + RW'(1);
				end
			end
		end
	end

	// one-entry job queue toward the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (push) begin
			job_valid_q <= 1'b1;
		end else if (job_pop) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			job_row_q <= out_row_q;
			job_col_q <= out_col_q;
			job_last_q <= last;
		end
	end

	assign job_valid = job_valid_q;
	assign job_row = job_row_q;
	assign job_col = job_col_q;
	assign job_last = job_last_q;

endmodule

@@ src/mpmf_back.sv @@
// back end: line ring memory, mirrored window gather and insertion sorter
// holds the result register; uses mpmf_pkg
`timescale 1ns / 1ps

module mpmf_back #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HALF = 3,
	parameter int CW = 10,
	parameter int RW = 10,
	parameter int HW = 2,
	parameter int RB = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CW-1:0]            w_last,
	input  logic [RW-1:0]            h_last,
	input  logic [HW-1:0]            a_eff,
	input  logic [HW-1:0]            b_eff,
	input  logic                     mem_we,
	input  logic [RB-1:0]            mem_wring,
	input  logic [CW-1:0]            mem_wcol,
	input  logic [mpmf_pkg::PIX_W-1:0] mem_wdata,
	input  logic                     job_valid,
	input  logic [RW-1:0]            job_row,
	input  logic [CW-1:0]            job_col,
	input  logic                     job_last,
	output logic                     job_pop,
	output logic                     back_idle,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [mpmf_pkg::PIX_W-1:0] median_out,
	output logic                     frame_last
);

	localparam int RING = 1 << $clog2(2 * MAX_HALF + 2);
	localparam int AW = $clog2(RING * MAX_WIDTH);
	localparam int WIN = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
	localparam int NW = $clog2(WIN + 1);
	localparam int IW = $clog2(WIN);
	localparam int XW = ((RW > CW) ? RW : CW) + 3;
	localparam int PW = mpmf_pkg::PIX_W;

	logic [PW-1:0] mem [RING * MAX_WIDTH];
	logic [PW-1:0] rdata_s1;
	logic          rd_valid_s1;
	logic [PW-1:0] win_q [WIN];
	logic [PW-1:0] win_n [WIN];
	logic [WIN-1:0] le;
	logic [NW-1:0] n_q;
	logic [HW:0]   s_q, t_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          last_q, res_valid_q, res_last_q, issue;
	logic [PW-1:0] res_q;
	logic [XW-1:0] mrow, mcol;
	logic [AW-1:0] raddr, waddr;
	mpmf_pkg::back_state_t state_q;

	function automatic logic [XW-1:0] mirror(input logic signed [XW-1:0] c,
		input logic signed [XW-1:0] off, input logic signed [XW-1:0] lim);
		logic signed [XW-1:0] r;
		r = c - off;
		if (r < 0) begin
			r = -r;
		end else if (r > lim) begin
			r = c + off;
		end
		if (r < 0) begin
			r = '0;
		end
		if (r > lim) begin
			r = lim;
		end
		return r;
	endfunction

	assign back_idle = (state_q == mpmf_pkg::ST_IDLE);
	assign job_pop = job_valid && back_idle && !res_valid_q;
	assign issue = (state_q == mpmf_pkg::ST_RUN);

	assign mrow = mirror(XW'(row_q), XW'(s_q) - XW'(a_eff), XW'(h_last));
	assign mcol = mirror(XW'(col_q), XW'(t_q) - XW'(b_eff), XW'(w_last));
	assign raddr = AW'(mrow[RB-1:0]) * AW'(MAX_WIDTH) + AW'(mcol);
	assign waddr = AW'(mem_wring) * AW'(MAX_WIDTH) + AW'(mem_wcol);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpmf_pkg::ST_IDLE;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				mpmf_pkg::ST_IDLE: begin
					if (job_pop) begin
						state_q <= mpmf_pkg::ST_RUN;
					end
				end
				mpmf_pkg::ST_RUN: begin
					if (t_q == {b_eff, 1'b0} && s_q == {a_eff, 1'b0}) begin
						state_q <= mpmf_pkg::ST_FLUSH;
					end
				end
				mpmf_pkg::ST_FLUSH: begin
					state_q <= mpmf_pkg::ST_FIN;
				end
				mpmf_pkg::ST_FIN: begin
					res_valid_q <= 1'b1;
					state_q <= mpmf_pkg::ST_IDLE;
				end
				default: begin
					state_q <= mpmf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// window walk, row offset outer and column offset inner
	always_ff @(posedge clk) begin
		if (job_pop) begin
			row_q <= job_row;
			col_q <= job_col;
			last_q <= job_last;
			s_q <= '0;
			t_q <= '0;
		end else if (issue) begin
			if (t_q == {b_eff, 1'b0}) begin
				t_q <= '0;
				s_q <= s_q + (HW+1)'(1);
			end else begin
				t_q <= t_q + (HW+1)'(1);
			end
		end
		if (state_q == mpmf_pkg::ST_FIN) begin
			res_q <= win_q[IW'(n_q >> 1)];
			res_last_q <= last_q;
		end
	end

	// sorted insertion: entries not above the new value stay, the rest shift up
	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			le[j] = (NW'(j) < n_q) && (win_q[j] <= rdata_s1);
		end
		win_n[0] = le[0] ? win_q[0] : rdata_s1;
		for (int j = 1; j < WIN; j++) begin
			if (le[j]) begin
				win_n[j] = win_q[j];
			end else if (le[j-1]) begin
				win_n[j] = rdata_s1;
			end else begin
				win_n[j] = win_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (job_pop) begin
			n_q <= '0;
		end else if (rd_valid_s1) begin
			n_q <= n_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			win_q <= win_n;
		end
	end

	assign res_valid = res_valid_q;
	assign median_out = res_q;
	assign frame_last = res_last_q;

endmodule

@@ src/mirror_padded_median_filter.sv @@
// a transaction that makes a centre ready queues a job; the back end pops it, gathers the window
// in ST_RUN with one read per cycle from the line ring into the insertion sorter, then passes
// ST_FLUSH and ST_FIN before res_valid rises; no transaction is taken until the back end is idle
// reset: counters, queue and result clear at once; ring memory is not cleared
// top level: apb register file, clamping, front and back ends; uses mpmf_pkg,
// mpmf_front and mpmf_back
`timescale 1ns / 1ps

module mirror_padded_median_filter #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_HALF = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mpmf_pkg::ADDR_W-1:0] paddr,
	input  logic [mpmf_pkg::DATA_W-1:0] pwdata,
	output logic [mpmf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic                        action,
	input  logic [mpmf_pkg::PIX_W-1:0]  pixel_in,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [mpmf_pkg::PIX_W-1:0]  median_out,
	output logic                        frame_last
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HALF + 1);
	localparam int RB = $clog2(2 * MAX_HALF + 2);
	localparam int EW = 14;

	logic [mpmf_pkg::CFG_W-1:0]      frame_width_q, frame_height_q;
	logic [mpmf_pkg::HALF_CFG_W-1:0] half_rows_q, half_cols_q;
	logic [CW-1:0] w_last;
	logic [RW-1:0] h_last;
	logic [HW-1:0] a_eff, b_eff;
	logic [EW-1:0] fw_ext, fh_ext;
	logic          cfg_wr, back_idle, mem_we, job_valid, job_last, job_pop;
	logic [RB-1:0] mem_wring;
	logic [CW-1:0] mem_wcol, job_col;
	logic [RW-1:0] job_row;
	logic [mpmf_pkg::PIX_W-1:0] mem_wdata;
	mpmf_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign ridx = mpmf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 11'd640;
			frame_height_q <= 11'd480;
			half_rows_q <= 2'd1;
			half_cols_q <= 2'd1;
		end else if (cfg_wr) begin
			unique case (ridx)
				mpmf_pkg::REG_FRAME_WIDTH:  frame_width_q <= pwdata[mpmf_pkg::CFG_W-1:0];
				mpmf_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[mpmf_pkg::CFG_W-1:0];
				mpmf_pkg::REG_HALF_ROWS:    half_rows_q <= pwdata[mpmf_pkg::HALF_CFG_W-1:0];
				mpmf_pkg::REG_HALF_COLS:    half_cols_q <= pwdata[mpmf_pkg::HALF_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			mpmf_pkg::REG_FRAME_WIDTH:  prdata = mpmf_pkg::DATA_W'(frame_width_q);
			mpmf_pkg::REG_FRAME_HEIGHT: prdata = mpmf_pkg::DATA_W'(frame_height_q);
			mpmf_pkg::REG_HALF_ROWS:    prdata = mpmf_pkg::DATA_W'(half_rows_q);
			mpmf_pkg::REG_HALF_COLS:    prdata = mpmf_pkg::DATA_W'(half_cols_q);
			default:                    prdata = '0;
		endcase
	end

	// clamp sizes into the supported range, kept as last index
	assign fw_ext = EW'(frame_width_q);
	assign fh_ext = EW'(frame_height_q);

	always_comb begin
		if (fw_ext == '0) begin
			w_last = '0;
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			w_last = CW'(MAX_WIDTH - 1);
		end else begin
			w_last = CW'(fw_ext - EW'(1));
		end
		if (fh_ext == '0) begin
			h_last = '0;
		end else if (fh_ext > EW'(MAX_HEIGHT)) begin
			h_last = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last = RW'(fh_ext - EW'(1));
		end
		a_eff = (32'(half_rows_q) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_rows_q);
		b_eff = (32'(half_cols_q) > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_cols_q);
	end

	mpmf_front #(.CW(CW), .RW(RW), .HW(HW), .RB(RB)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg_restart(cfg_wr),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .action(action), .pixel_in(pixel_in),
		.w_last(w_last), .h_last(h_last), .a_eff(a_eff), .b_eff(b_eff),
		.back_idle(back_idle), .mem_we(mem_we), .mem_wring(mem_wring),
		.mem_wcol(mem_wcol), .mem_wdata(mem_wdata), .job_valid(job_valid),
		.job_row(job_row), .job_col(job_col), .job_last(job_last), .job_pop(job_pop)
	);

	mpmf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HALF(MAX_HALF), .CW(CW), .RW(RW), .HW(HW),
		.RB(RB)) u_back (
		.clk(clk), .arst_n(arst_n), .w_last(w_last), .h_last(h_last),
		.a_eff(a_eff), .b_eff(b_eff), .mem_we(mem_we), .mem_wring(mem_wring),
		.mem_wcol(mem_wcol), .mem_wdata(mem_wdata), .job_valid(job_valid),
		.job_row(job_row), .job_col(job_col), .job_last(job_last), .job_pop(job_pop),
		.back_idle(back_idle), .res_valid(res_valid), .res_ready(res_ready),
		.median_out(median_out), .frame_last(frame_last)
	);

`ifndef SYNTHESIS
	// a ring write never lands while the back end walks a window
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> back_idle) else $error("ring write during window gather");
	// a new job is taken only when the previous one has left the queue
	a_push_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |-> !job_valid) else $error("job queue overrun");
	// the back end starts a window only with the result register free
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !res_valid) else $error("result overwritten");
	// a popped job leaves the queue on the next cycle
	a_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> !job_valid) else $error("job not retired");
`endif

endmodule

@@ test/mpmf_checker.sv @@
// scoreboard for the mirror padded median filter: tracks register writes and pixel
// transactions, predicts each median and compares the result channel; uses mpmf_pkg
`timescale 1ns / 1ps

module mpmf_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [mpmf_pkg::ADDR_W-1:0] paddr,
	input  logic [mpmf_pkg::DATA_W-1:0] pwdata,
	input  logic                        pix_valid,
	input  logic                        pix_ready,
	input  logic                        action,
	input  logic [mpmf_pkg::PIX_W-1:0]  pixel_in,
	input  logic                        res_valid,
	input  logic                        res_ready,
	input  logic [mpmf_pkg::PIX_W-1:0]  median_out,
	input  logic                        frame_last,
	output int                          errors,
	output int                          pending,
	output int                          frames_done,
	output int                          results_seen
);

	localparam int LINE_MAX = 1024;
	localparam int HALF_MAX = 3;
	localparam int RING_LINES = 2 * HALF_MAX + 2;

	typedef struct packed {
		logic [mpmf_pkg::PIX_W-1:0] med;
		logic                       last;
	} median_t;

	logic [mpmf_pkg::PIX_W-1:0] line_ring [0:RING_LINES*LINE_MAX-1];
	logic [mpmf_pkg::CFG_W-1:0] width_reg, height_reg;
	logic [mpmf_pkg::HALF_CFG_W-1:0] hrow_reg, hcol_reg;
	int unsigned wr_row, wr_col, rd_row, rd_col;
	bit frame_got;
	median_t median_q[$];

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int reflect(int ctr, int off, int size);
		int r;
		r = ctr - off;
		if (r < 0) begin
			r = -r;
		end else if (r >= size) begin
			r = ctr + off;
		end
		if (r < 0) r = 0;
		if (r > size - 1) r = size - 1;
		return r;
	endfunction

	task automatic frame_restart();
		wr_row = 0;
		wr_col = 0;
		rd_row = 0;
		rd_col = 0;
		frame_got = 0;
	endtask

	task automatic report(input string what, input int got_v, input int exp_v);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
		errors++;
	endtask

	// one pixel or drain transaction; pushes the median it makes ready, if any
	task automatic median_step(input logic act, input logic [mpmf_pkg::PIX_W-1:0] px);
		int unsigned w, h, a, b, rmax, cmax, need, got;
		int s, t, r, c, n, j;
		logic [mpmf_pkg::PIX_W-1:0] win [0:48];
		logic [mpmf_pkg::PIX_W-1:0] v;
		median_t m;
		w = clip(width_reg, 1, LINE_MAX);
		h = clip(height_reg, 1, LINE_MAX);
		a = clip(hrow_reg, 0, HALF_MAX);
		b = clip(hcol_reg, 0, HALF_MAX);
		n = 0;
		if (wr_row >= h || wr_col >= w || rd_row >= h || rd_col >= w) frame_restart();
		if (!act && !frame_got) begin
			line_ring[(wr_row % RING_LINES) * LINE_MAX + wr_col] = px;
			if (wr_col + 1 < w) begin
				wr_col++;
			end else if (wr_row + 1 < h) begin
				wr_col = 0;
				wr_row++;
			end else begin
				frame_got = 1;
			end
		end
		rmax = rd_row + a;
		if (rmax > h - 1) rmax = h - 1;
		cmax = rd_col + b;
		if (cmax > w - 1) cmax = w - 1;
		need = rmax * w + cmax;
		got = wr_row * w + wr_col;
		if (!frame_got && need >= got) return;
		for (s = -int'(a); s <= int'(a); s++) begin
			r = reflect(rd_row, s, h);
			for (t = -int'(b); t <= int'(b); t++) begin
				c = reflect(rd_col, t, w);
				v = line_ring[(r % RING_LINES) * LINE_MAX + c];
				for (j = n; j > 0 && win[j-1] > v; j--) win[j] = win[j-1];
				win[j] = v;
				n++;
			end
		end
		m.med = win[n/2];
		m.last = 0;
		if (rd_col + 1 < w) begin
			rd_col++;
		end else if (rd_row + 1 < h) begin
			rd_col = 0;
			rd_row++;
		end else begin
			m.last = 1;
			frame_restart();
		end
		median_q.push_back(m);
	endtask

	always @(posedge clk or negedge arst_n) begin
		median_t e;
		int qn;
		if (!arst_n) begin
			width_reg = 640;
			height_reg = 480;
			hrow_reg = 1;
			hcol_reg = 1;
			frame_restart();
			median_q.delete();
			errors = 0;
			pending <= 0;
			frames_done <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (mpmf_pkg::reg_idx_t'(paddr[mpmf_pkg::ADDR_W-1:2]))
					mpmf_pkg::REG_FRAME_WIDTH:  width_reg = pwdata[mpmf_pkg::CFG_W-1:0];
					mpmf_pkg::REG_FRAME_HEIGHT: height_reg = pwdata[mpmf_pkg::CFG_W-1:0];
					mpmf_pkg::REG_HALF_ROWS:    hrow_reg = pwdata[mpmf_pkg::HALF_CFG_W-1:0];
					mpmf_pkg::REG_HALF_COLS:    hcol_reg = pwdata[mpmf_pkg::HALF_CFG_W-1:0];
				endcase
				frame_restart();
			end
			if (pix_valid && pix_ready) begin
				qn = median_q.size();
				median_step(action, pixel_in);
				if (median_q.size() > qn && median_q[$].last) frames_done <= frames_done + 1;
			end
			if (res_valid && res_ready) begin
				results_seen <= results_seen + 1;
				if (median_q.size() == 0) begin
					report("result count", 1, 0);
				end else begin
					e = median_q.pop_front();
					if (median_out !== e.med) report("median_out", median_out, e.med);
					if (frame_last !== e.last) report("frame_last", frame_last, e.last);
				end
			end
			pending <= median_q.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// top of the median filter bench: clock, reset, register writes, pixel stimulus,
// receiver stalls and verdict; uses mpmf_pkg, mirror_padded_median_filter, mpmf_checker
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE = 64;
	localparam int CUT_MAX = 40;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [mpmf_pkg::ADDR_W-1:0] paddr = '0;
	logic [mpmf_pkg::DATA_W-1:0] pwdata = '0;
	logic [mpmf_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic pix_valid = 0, pix_ready;
	logic action = 0;
	logic [mpmf_pkg::PIX_W-1:0] pixel_in = '0;
	logic res_valid, res_ready = 0;
	logic [mpmf_pkg::PIX_W-1:0] median_out;
	logic frame_last;
	int errors, pending, frames_done, results_seen;
	int burst_left = 0;
	bit hold_done = 0;

	always #6 clk = ~clk;

	mirror_padded_median_filter u_top (.*);

	mpmf_checker u_checker (.*);

	task automatic reg_write(input mpmf_pkg::reg_idx_t idx, input int unsigned val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send(input logic act, input logic [mpmf_pkg::PIX_W-1:0] px);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				pix_valid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1;
		action <= act;
		pixel_in <= px;
		do @(posedge clk); while (!pix_ready);
	endtask

	task automatic go_idle();
		@(negedge clk);
		pix_valid <= 0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [mpmf_pkg::PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return mpmf_pkg::PIX_W'($urandom);
		endcase
	endfunction

	// pixels, stray drains, then unless cut short drains (and ignored pixels) till it closes
	task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned a,
			input int unsigned b, input bit cut_short);
		int unsigned npix, target;
		reg_write(mpmf_pkg::REG_FRAME_WIDTH, w);
		reg_write(mpmf_pkg::REG_FRAME_HEIGHT, h);
		reg_write(mpmf_pkg::REG_HALF_ROWS, a);
		reg_write(mpmf_pkg::REG_HALF_COLS, b);
		npix = (w < 1 ? 1 : (w > 1024 ? 1024 : w)) * (h < 1 ? 1 : (h > 1024 ? 1024 : h));
		if (cut_short) npix = $urandom_range(1, (npix > CUT_MAX) ? CUT_MAX : npix);
		target = frames_done + 1;
		for (int unsigned i = 0; i < npix; i++) begin
			if ($urandom_range(0, 5) == 0) send(1'b1, mpmf_pkg::PIX_W'($urandom));
			send(1'b0, pick_pixel());
		end
		if (!cut_short) begin
			while (frames_done < target) begin
				send($urandom_range(0, 3) != 0, mpmf_pkg::PIX_W'($urandom));
			end
		end
		go_idle();
	endtask

	// receiver: changing stall pattern plus one long hold-off to back the block up
	initial begin
		int mode, left;
		left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 20 && arst_n) begin
				hold_done = 1;
				res_ready <= 0;
				repeat (600) @(negedge clk);
			end
			if (left == 0) begin
				left = $urandom_range(10, 80);
				mode = $urandom_range(0, 2);
			end
			left--;
			case (mode)
				0: res_ready <= 1;
				1: res_ready <= $urandom_range(0, 1);
				default: res_ready <= ($urandom_range(0, 5) != 0);
			endcase
		end
	end

	initial begin
		#30ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		repeat (2) @(negedge clk);
		// directed: tiny frames, clamped sizes, widest and tallest frames cut short
		run_frame(4, 3, 1, 1, 0);
		run_frame(1, 1, 0, 0, 0);
		run_frame(0, 0, 3, 3, 0);
		run_frame(5, 4, 3, 3, 0);
		run_frame(2047, 1, 3, 0, 1);
		run_frame(1, 2047, 0, 3, 1);
		run_frame(3, 5, 2, 1, 1);
		run_frame(3, 5, 2, 1, 0);
		run_frame(1024, 2, 1, 3, 1);
		// random frames, a few abandoned part way
		for (int k = 0; k < 8; k++) begin
			run_frame($urandom_range(1, 10), $urandom_range(1, 6), $urandom_range(0, 3),
				$urandom_range(0, 3), $urandom_range(0, 6) == 0);
		end
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
